// ===== rtl/mhk_pkg.sv =====
// Package for the magnetometer heading filter: payload structs, register indexes,
// controller states, CORDIC angle table and defaults. No dependencies.
package mhk_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FIELD_BITS   = 16;
    localparam int CORDIC_ITERS = 28;
    localparam int ITER_W       = 5;
    localparam int DIV_STEPS    = 16;
    localparam int DIV_W        = 5;

    localparam logic [31:0] DEF_Q      = 32'd66;
    localparam logic [31:0] DEF_R      = 32'd262144;
    localparam logic [31:0] DEF_P0     = 32'd26214400;
    localparam logic [15:0] DEF_STABLE = 16'd18;

    localparam logic [2:0] REG_MANUAL   = 3'd0;
    localparam logic [2:0] REG_INIT_ROT = 3'd1;
    localparam logic [2:0] REG_MIN_SQ   = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_Q        = 3'd4;
    localparam logic [2:0] REG_R        = 3'd5;
    localparam logic [2:0] REG_P0       = 3'd6;
    localparam logic [2:0] REG_STABLE   = 3'd7;

    // one magnetometer reading
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] field_x;
        logic signed [FIELD_BITS-1:0] field_y;
        logic                         read_ok;
    } in_item_t;

    // one result per reading
    typedef struct packed {
        logic                  rotation_changed;
        logic [1:0]            rotation;
        logic [ANGLE_BITS-1:0] world_heading;
        logic                  sample_used;
        logic                  healthy;
        logic [15:0]           last_gain;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAG, ST_CORDIC, ST_ROUND, ST_DIV,
        ST_EST, ST_COV, ST_SECTOR, ST_HYST, ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mag;
        logic cordic_init;
        logic cordic_step;
        logic round;
        logic div_init;
        logic div_step;
        logic est;
        logic cov;
        logic sector;
        logic hyst;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic go;
        logic field_ok;
        logic seeded;
        logic cordic_done;
        logic div_done;
    } status_t;

    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/mhk_ctrl.sv =====
// Sequencer for the heading filter: steps the datapath through one sample.
// Depends on mhk_pkg.
module mhk_ctrl
    import mhk_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    // next sample may start while the previous result waits; it is held in ST_OUT
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                cmd.mag    = 1'b1;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (!status.go || !status.field_ok) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.cordic_init = 1'b1;
                    state_next      = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (!status.cordic_done) begin
                    cmd.cordic_step = 1'b1;
                end else begin
                    cmd.round  = 1'b1;
                    state_next = status.seeded ? ST_DIV : ST_SECTOR;
                end
            end
            ST_DIV: begin
                cmd.div_init = 1'b1;
                state_next   = ST_EST;
            end
            ST_EST: begin
                if (!status.div_done) begin
                    cmd.div_step = 1'b1;
                end else begin
                    cmd.est    = 1'b1;
                    state_next = ST_COV;
                end
            end
            ST_COV: begin
                cmd.cov    = 1'b1;
                state_next = ST_SECTOR;
            end
            ST_SECTOR: begin
                cmd.sector = 1'b1;
                state_next = ST_HYST;
            end
            ST_HYST: begin
                cmd.hyst   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    cmd.emit     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/mhk_datapath.sv =====
// Datapath: config registers, filter state, CORDIC, restoring divider, hysteresis,
// result register. Depends on mhk_pkg.
module mhk_datapath
    import mhk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  in_item_t    in_data,
    input  cmd_t        cmd,
    output status_t     status,
    output out_item_t   out_data
);

    localparam int SQ_W     = 2 * FIELD_BITS + 1;
    localparam int CW       = 44;   // 40-bit scaled input plus CORDIC growth
    localparam int SHIFT_IN = 40 - FIELD_BITS;
    localparam int PROD_W   = ANGLE_BITS + 19;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    // configuration
    logic        manual_reg;
    logic [31:0] min_sq_reg, q_reg, r_reg, p0_reg;
    logic [15:0] offset_reg, stable_req_reg;

    // filter state
    logic [ANGLE_BITS-1:0] est_reg;
    logic [31:0] cov_reg;
    logic [15:0] gain_reg, count_reg;
    logic        have_reg, health_reg;
    logic [1:0]  rot_reg, cand_reg;

    // per-sample work registers
    logic signed [FIELD_BITS-1:0] x_reg, y_reg;
    logic        ok_reg, go_reg, field_ok_reg, used_reg, changed_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [31:0] z_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [ANGLE_BITS-1:0] raw_reg;
    logic [31:0] pp_reg;
    logic [33:0] den_reg, rem_reg;
    logic [15:0] quo_reg;
    logic [DIV_W-1:0] div_cnt_reg;
    logic [1:0]  sec_reg;
    out_item_t   out_reg;

    function automatic logic [ANGLE_BITS-1:0] raw_next(input logic [31:0] z);
        return z[31 -: ANGLE_BITS];
    endfunction

    logic [ANGLE_BITS-1:0] off_scaled;
    assign off_scaled = ANGLE_BITS'({offset_reg, 16'b0} >> (32 - ANGLE_BITS));

    logic [1:0] init_rot_eff;
    assign init_rot_eff = (cfg_data[1:0] == 2'd3) ? 2'd0 : cfg_data[1:0];

    logic [31:0] q_eff, r_eff, p0_eff;
    logic [15:0] stable_eff;
    assign q_eff      = (q_reg == 32'd0) ? DEF_Q : q_reg;
    assign r_eff      = (r_reg == 32'd0) ? DEF_R : r_reg;
    assign p0_eff     = (p0_reg == 32'd0) ? DEF_P0 : p0_reg;
    assign stable_eff = (stable_req_reg == 16'd0) ? DEF_STABLE : stable_req_reg;

    // field magnitude
    logic [SQ_W-1:0] msq;
    logic signed [2*FIELD_BITS-1:0] xx, yy;
    assign xx  = x_reg * x_reg;
    assign yy  = y_reg * y_reg;
    assign msq = {1'b0, xx} + {1'b0, yy};

    // CORDIC step
    logic signed [CW-1:0] dx, dy, sx, sy;
    logic [31:0] at;
    assign dx = cy_reg >>> iter_reg;
    assign dy = cx_reg >>> iter_reg;
    assign at = atan_entry(iter_reg);

    logic [31:0] z_round;
    assign z_round = z_reg + (32'd1 << (31 - ANGLE_BITS));

    assign sx = CW'(signed'(x_reg)) <<< SHIFT_IN;
    assign sy = CW'(signed'(y_reg)) <<< SHIFT_IN;

    // predicted covariance, saturated to 32 bits
    logic [32:0] pp_sum;
    logic [31:0] pp_sat;
    assign pp_sum = {1'b0, cov_reg} + {1'b0, q_eff};
    assign pp_sat = pp_sum[32] ? 32'hFFFFFFFF : pp_sum[31:0];

    // gain = (pp<<16)/(pp+R); pp < den, so the top 32 quotient bits are zero and
    // the remainder starts at pp, leaving 16 restoring steps
    logic [34:0] div_shift;
    logic        div_fit;
    assign div_shift = {rem_reg, 1'b0};
    assign div_fit   = (div_shift >= {1'b0, den_reg});

    // Kalman estimate update
    logic [ANGLE_BITS-1:0] innov_u;
    logic signed [ANGLE_BITS:0] innov;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] delta;
    logic [16:0] k17;
    assign k17     = {1'b0, quo_reg};
    assign innov_u = raw_reg - est_reg;
    assign innov   = {innov_u[ANGLE_BITS-1], innov_u};
    assign prod    = signed'(k17) * innov + PROD_W'(32768);
    assign delta   = prod >>> 16;

    logic [48:0] cov_prod;
    assign cov_prod = (17'd65536 - {1'b0, gain_reg}) * pp_reg;

    logic [ANGLE_BITS-1:0] adj;
    logic [ANGLE_BITS+1:0] three_adj;
    logic [1:0] sec_raw;
    assign adj       = est_reg - off_scaled;
    assign three_adj = {2'b0, adj} + {1'b0, adj, 1'b0} + {2'b0, HALF_TURN};
    assign sec_raw   = (three_adj[ANGLE_BITS+1:ANGLE_BITS] == 2'd3)
                       ? 2'd0 : three_adj[ANGLE_BITS+1:ANGLE_BITS];

    logic [15:0] count_inc;
    assign count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_reg     <= 1'b0;
            min_sq_reg     <= 32'd0;
            offset_reg     <= 16'd0;
            q_reg          <= DEF_Q;
            r_reg          <= DEF_R;
            p0_reg         <= DEF_P0;
            stable_req_reg <= DEF_STABLE;
            est_reg        <= '0;
            cov_reg        <= DEF_P0;
            gain_reg       <= 16'd0;
            have_reg       <= 1'b0;
            health_reg     <= 1'b1;
            rot_reg        <= 2'd0;
            cand_reg       <= 2'd0;
            count_reg      <= 16'd0;
            used_reg       <= 1'b0;
            changed_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MANUAL:   manual_reg <= cfg_data[0];
                    REG_INIT_ROT: begin
                        rot_reg   <= init_rot_eff;
                        cand_reg  <= init_rot_eff;
                        count_reg <= 16'd0;
                    end
                    REG_MIN_SQ:   min_sq_reg     <= cfg_data;
                    REG_OFFSET:   offset_reg     <= cfg_data[15:0];
                    REG_Q:        q_reg          <= cfg_data;
                    REG_R:        r_reg          <= cfg_data;
                    REG_P0:       p0_reg         <= cfg_data;
                    REG_STABLE:   stable_req_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                used_reg    <= 1'b0;
                changed_reg <= 1'b0;
            end
            if (cmd.mag && health_reg && !manual_reg && !ok_reg) health_reg <= 1'b0;
            if (cmd.round) begin
                used_reg <= 1'b1;
                if (!have_reg) begin
                    est_reg  <= raw_next(z_round);
                    cov_reg  <= p0_eff;
                    have_reg <= 1'b1;
                end
            end
            if (cmd.est) begin
                gain_reg <= quo_reg;
                est_reg  <= est_reg + delta[ANGLE_BITS-1:0];
            end
            if (cmd.cov) cov_reg <= cov_prod[47:16];
            if (cmd.hyst) begin
                if (sec_reg != cand_reg) begin
                    cand_reg  <= sec_reg;
                    count_reg <= 16'd1;
                end else if (cand_reg != rot_reg && count_inc >= stable_eff) begin
                    rot_reg     <= cand_reg;
                    count_reg   <= 16'd0;
                    changed_reg <= 1'b1;
                end else begin
                    count_reg <= count_inc;
                end
            end
        end
    end

    // work registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg  <= in_data.field_x;
            y_reg  <= in_data.field_y;
            ok_reg <= in_data.read_ok;
        end
        if (cmd.mag) go_reg <= health_reg && !manual_reg && ok_reg;
        if (cmd.mag) field_ok_reg <= (msq >= SQ_W'(min_sq_reg));
        if (cmd.cordic_init) begin
            iter_reg <= '0;
            if (x_reg == 0 && y_reg == 0) begin
                cx_reg <= '0;
                cy_reg <= '0;
                z_reg  <= 32'd0 - (32'd1 << (31 - ANGLE_BITS));
                iter_reg <= ITER_W'(CORDIC_ITERS);
            end else if (x_reg < 0) begin
                cx_reg <= -sx;
                cy_reg <= -sy;
                z_reg  <= 32'h80000000;
            end else begin
                cx_reg <= sx;
                cy_reg <= sy;
                z_reg  <= 32'd0;
            end
        end
        if (cmd.cordic_step) begin
            iter_reg <= iter_reg + 1'b1;
            if (cy_reg > 0) begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + at;
            end else begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - at;
            end
        end
        if (cmd.round) raw_reg <= raw_next(z_round);
        if (cmd.div_init) begin
            pp_reg      <= pp_sat;
            den_reg     <= {2'b0, pp_sat} + {2'b0, r_eff};
            rem_reg     <= {2'b0, pp_sat};
            quo_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_fit) begin
                rem_reg <= 34'(div_shift - {1'b0, den_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= div_shift[33:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.sector) sec_reg <= sec_raw;
        if (cmd.emit) begin
            out_reg <= '{rotation_changed: changed_reg,
                         rotation:         rot_reg,
                         world_heading:    est_reg - off_scaled,
                         sample_used:      used_reg,
                         healthy:          health_reg,
                         last_gain:        gain_reg};
        end
    end

    assign status.go          = go_reg;
    assign status.field_ok    = field_ok_reg;
    assign status.seeded      = have_reg;
    assign status.cordic_done = (iter_reg == ITER_W'(CORDIC_ITERS));
    assign status.div_done    = (div_cnt_reg == DIV_W'(DIV_STEPS));

    assign out_data = out_reg;

endmodule

// ===== rtl/mag_heading_kalman_rotation_select.sv =====
// Top level of the magnetometer heading filter with rotation selection.
// Depends on mhk_pkg, mhk_ctrl, mhk_datapath.
//
// Input channel s_*: one magnetometer reading per transfer (x, y, read status).
// Result channel m_*: one result per reading: rotation step, change flag,
// offset-adjusted filtered heading, used flag, health and last Kalman gain.
// Config channel cfg_*: register index and data; write only while idle.
//
// Path from input transfer to m_valid: a failed, ignored or weak sample goes from
// ST_CORDIC straight to ST_OUT; a good seed sample adds 28 CORDIC iterations plus
// rounding; a filter update adds 16 restoring divider steps and the estimate/covariance steps.
// One sample is processed at a time; s_ready rises the cycle after the result is
// registered, so a new reading is taken only once the previous result is registered.
// Reset (aresetn low, synchronous) loads register defaults and clears the
// filter state. If the receiver stalls, the result holds in the output register
// and the next sample is processed and then waits in the final state, with
// s_ready low, until that result has been transferred.
module mag_heading_kalman_rotation_select
    import mhk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mhk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mhk_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_data)
    );

endmodule

// ===== tb/mag_heading_kalman_rotation_select_test.sv =====
// Testbench for mag_heading_kalman_rotation_select: directed and random magnetometer
// readings under several register settings, checked against an in-bench heading filter.
// Depends on mhk_pkg and the block's RTL.
`timescale 1ns / 1ps

module mag_heading_kalman_rotation_select_test
    import mhk_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 120;
    localparam int HOLD_CYCLES = 400;

    class heading_filter_model;
        bit [31:0] manual, init_rot, min_sq, offset, q, r, p0, stable_req;
        bit [15:0] est, gain;
        bit [31:0] cov;
        bit [1:0]  rot, cand;
        bit [15:0] stable_cnt;
        bit        seeded, healthy;
        out_item_t expected_results[$];
        int        errors;

        function new();
            manual = 0; init_rot = 0; min_sq = 0; offset = 0;
            q = DEF_Q; r = DEF_R; p0 = DEF_P0; stable_req = DEF_STABLE;
            est = 0; cov = DEF_P0; gain = 0; seeded = 0; healthy = 1;
            rot = 0; cand = 0; stable_cnt = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, bit [31:0] v);
            case (idx)
                REG_MANUAL:   manual = v & 1;
                REG_INIT_ROT: begin
                    init_rot = v & 3;
                    rot = (init_rot == 3) ? 2'd0 : init_rot[1:0];
                    cand = rot;
                    stable_cnt = 0;
                end
                REG_MIN_SQ:   min_sq = v;
                REG_OFFSET:   offset = v & 16'hFFFF;
                REG_Q:        q = v;
                REG_R:        r = v;
                REG_P0:       p0 = v;
                REG_STABLE:   stable_req = v & 16'hFFFF;
                default: ;
            endcase
        endfunction

        function bit [15:0] cordic_angle(longint x, longint y);
            longint cx, cy, dx, dy;
            bit [31:0] z;
            cx = x * (64'sd1 << 24);
            cy = y * (64'sd1 << 24);
            z = 0;
            if (x == 0 && y == 0) return 16'd0;
            if (cx < 0) begin
                cx = -cx; cy = -cy; z = 32'h80000000;
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy > 0) begin
                    cx += dx; cy -= dy; z += atan_entry(i[ITER_W-1:0]);
                end else begin
                    cx -= dx; cy += dy; z -= atan_entry(i[ITER_W-1:0]);
                end
            end
            z += 32'h8000;
            return z[31:16];
        endfunction

        function void note_reading(logic signed [15:0] fx, logic signed [15:0] fy, logic ok);
            out_item_t res;
            longint x, y, msq, innov, delta;
            longint unsigned pp, s, k;
            bit [15:0] raw, adj, diff;
            bit [31:0] sec3;
            bit [1:0] sec;
            bit [15:0] need;
            res = '0;
            if (healthy && !manual) begin
                if (!ok) begin
                    healthy = 0;
                end else begin
                    x = fx; y = fy;
                    msq = x * x + y * y;
                    if (msq >= longint'(min_sq)) begin
                        raw = cordic_angle(x, y);
                        res.sample_used = 1;
                        if (!seeded) begin
                            est = raw;
                            cov = (p0 != 0) ? p0 : DEF_P0;
                            seeded = 1;
                        end else begin
                            pp = longint'(cov) + longint'((q != 0) ? q : DEF_Q);
                            if (pp > 64'hFFFFFFFF) pp = 64'hFFFFFFFF;
                            s = pp + longint'((r != 0) ? r : DEF_R);
                            k = (pp << 16) / s;
                            diff = raw - est;
                            innov = longint'(signed'(diff));
                            delta = (longint'(k) * innov + 32768) >>> 16;
                            est = est + delta[15:0];
                            cov = 32'(((65536 - k) * pp) >> 16);
                            gain = k[15:0];
                        end
                        adj = est - offset[15:0];
                        sec3 = (3 * 32'(adj) + 32'h8000) >> 16;
                        sec = 2'(sec3 % 3);
                        need = (stable_req[15:0] != 0) ? stable_req[15:0] : DEF_STABLE;
                        if (sec != cand) begin
                            cand = sec;
                            stable_cnt = 1;
                        end else begin
                            if (stable_cnt != 16'hFFFF) stable_cnt++;
                            if (cand != rot && stable_cnt >= need) begin
                                rot = cand;
                                stable_cnt = 0;
                                res.rotation_changed = 1;
                            end
                        end
                    end
                end
            end
            res.rotation = rot;
            res.world_heading = est - offset[15:0];
            res.healthy = healthy;
            res.last_gain = gain;
            expected_results.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.rotation_changed !== want.rotation_changed)
                $display("%0t: rotation_changed exp %0d got %0d", $realtime,
                         want.rotation_changed, got.rotation_changed);
            if (got.rotation !== want.rotation)
                $display("%0t: rotation exp %0d got %0d", $realtime,
                         want.rotation, got.rotation);
            if (got.world_heading !== want.world_heading)
                $display("%0t: world_heading exp %0d got %0d", $realtime,
                         want.world_heading, got.world_heading);
            if (got.sample_used !== want.sample_used)
                $display("%0t: sample_used exp %0d got %0d", $realtime,
                         want.sample_used, got.sample_used);
            if (got.healthy !== want.healthy)
                $display("%0t: healthy exp %0d got %0d", $realtime,
                         want.healthy, got.healthy);
            if (got.last_gain !== want.last_gain)
                $display("%0t: last_gain exp %0d got %0d", $realtime,
                         want.last_gain, got.last_gain);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    out_item_t   m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    heading_filter_model filt = new();
    int   cycles = 0;
    int   readings_sent = 0;
    int   tx_idle = 23, rx_idle = 51;
    int   base_x = 1000, base_y = 0, spread = 200;
    event hold_start;
    logic hold_active = 1'b0;

    mag_heading_kalman_rotation_select dut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    // receiver: random stalls, or a full stall during a hold-off
    always @(posedge aclk) begin
        if (hold_active) begin
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
        if (aresetn && m_valid && m_ready)
            filt.check_result(m_data);
    end

    task automatic send_reading(logic signed [15:0] fx, logic signed [15:0] fy, logic ok);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        end
        s_valid <= 1;
        s_data <= '{field_x: fx, field_y: fy, read_ok: ok};
        do @(posedge aclk); while (!s_ready);
        filt.note_reading(fx, fy, ok);
        readings_sent++;
        if (readings_sent < 270) begin
            tx_idle = 23; rx_idle = 51;
        end else if (readings_sent < 540) begin
            tx_idle = 51; rx_idle = 23;
        end else begin
            tx_idle = 0; rx_idle = 0;
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        do @(posedge aclk); while (filt.expected_results.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        filt.write_reg(idx, v);
    endtask

    task automatic apply_settings(bit [31:0] man, bit [31:0] irot, bit [31:0] msq,
                                  bit [31:0] off, bit [31:0] q, bit [31:0] r,
                                  bit [31:0] p0, bit [31:0] st);
        cfg_write(REG_MANUAL, man);
        cfg_write(REG_INIT_ROT, irot);
        cfg_write(REG_MIN_SQ, msq);
        cfg_write(REG_OFFSET, off);
        cfg_write(REG_Q, q);
        cfg_write(REG_R, r);
        cfg_write(REG_P0, p0);
        cfg_write(REG_STABLE, st);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] sat16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // mostly readings clustered around a field direction that now and then jumps to a new random value
    task automatic random_readings(int n, int fail_pct);
        int sel;
        logic signed [15:0] fx, fy;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(29) == 0) begin
                base_x = int'($urandom_range(65535)) - 32768;
                base_y = int'($urandom_range(65535)) - 32768;
                spread = 1 << $urandom_range(12);
            end
            sel = $urandom_range(99);
            if (sel < 70) begin
                fx = sat16(base_x + int'($urandom_range(2 * spread)) - spread);
                fy = sat16(base_y + int'($urandom_range(2 * spread)) - spread);
            end else if (sel < 88) begin
                fx = 16'($urandom);
                fy = 16'($urandom);
            end else begin
                fx = sat16(int'($urandom_range(128)) - 64);
                fy = sat16(int'($urandom_range(128)) - 64);
            end
            send_reading(fx, fy, ($urandom_range(99) >= fail_pct));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: axis and corner extremes, zero field, a settled cluster
        send_reading(16'sd0, 16'sd0, 1'b1);
        send_reading(16'sd32767, 16'sd0, 1'b1);
        send_reading(16'sh8000, 16'sd0, 1'b1);
        send_reading(16'sd0, 16'sd32767, 1'b1);
        send_reading(16'sd0, 16'sh8000, 1'b1);
        send_reading(16'sh8000, 16'sh8000, 1'b1);
        send_reading(16'sd32767, 16'sd32767, 1'b1);
        send_reading(-16'sd1, 16'sd0, 1'b1);
        send_reading(16'sd1, -16'sd1, 1'b1);
        send_reading(16'sh8000, 16'sd32767, 1'b1);
        for (int i = 0; i < 12; i++) send_reading(-16'sd2000, 16'sd3400, 1'b1);
        drain();

        // long receiver hold-off while the sender keeps offering readings
        apply_settings(0, 1, 0, 16384, 1, 1, 1, 1);
        -> hold_start;
        random_readings(110, 0);
        drain();

        apply_settings(0, 2, 32'h80000000, 65535, 32'hFFFFFFFF, 32'hFFFFFFFF,
                       32'hFFFFFFFF, 65535);
        for (int i = 0; i < 6; i++) send_reading(16'sh8000, 16'sh8000, 1'b1);
        random_readings(100, 0);
        drain();

        // zero noise and stability registers fall back to defaults; step 3 acts as 0
        apply_settings(0, 3, 1000000, $urandom_range(65535), 0, 0, 0, 0);
        random_readings(110, 0);
        drain();

        // manual mode: failed reads must not latch the health flag
        apply_settings(1, 0, 0, 0, 66, 262144, 26214400, 3);
        random_readings(60, 20);
        drain();

        apply_settings(0, 2, 5000000, 21845, 1000, 100000, 5000, 2);
        random_readings(150, 0);
        drain();

        apply_settings(0, 1, $urandom_range(20000000), $urandom, $urandom_range(1, 100000),
                       $urandom_range(1, 1000000), $urandom_range(1, 30000000), 4);
        random_readings(200, 0);
        // a failed read latches the block unhealthy for the rest of the run
        send_reading(16'sd500, 16'sd500, 1'b0);
        random_readings(20, 10);
        drain();

        if (filt.errors == 0 && filt.expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mhk_pkg.sv
rtl/mhk_ctrl.sv
rtl/mhk_datapath.sv
rtl/mag_heading_kalman_rotation_select.sv
tb/mag_heading_kalman_rotation_select_test.sv
